[sv/grw_pkg.sv]
// ----------------------------------------------------------------------------
// grw_pkg: shared types and constants
// Map geometry, arithmetic widths, queue item layout and register indexes
// for the grid ray wall hit core.
// ----------------------------------------------------------------------------
package grw_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // config register width (fixed by the register map)
  localparam int DIM_W      = 7;
  // signed map position, holds -1 .. 64
  localparam int POS_W      = 10;

  // shared divider: 50-bit dividend, 24-bit divisor
  localparam int DIV_NUM_W  = 50;
  localparam int DIV_DEN_W  = 24;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
  // root input: (dx^2 + dy^2) << 16
  localparam int SQ_W       = 49;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [DIV_NUM_W-1:0] ONE_Q30 = DIV_NUM_W'(1) << 30;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // config register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic        [11:0] cell_index;
    logic        [3:0]  cell_value;
    logic        [15:0] origin_x;
    logic        [15:0] origin_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } item_t;

  // back end status toward the front end
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

[sv/grid_ray_wall_hit_core.sv]
// ----------------------------------------------------------------------------
// grid_ray_wall_hit_core: DDA ray caster over a 4-bit cell map
// Top level: config registers, command intake and the ray walker.
// ----------------------------------------------------------------------------
// Usage: after reset the map is cleared by a sweep over all 4096 cells, one
// cell per cycle, during which busy stays high (config writes still land). A
// word is taken when start is high and busy is low; up to two words queue
// ahead of the walker. Every word gives exactly one result, shown for one
// cycle with out_valid; the receiver cannot stall, so results are never held
// back. A cell write is done in the idle state. A cast runs two divisions
// (start, 50 quotient bits, done) for the step lengths, works out the first
// crossings, then walks the grid, each step passing the step, map read and
// check states; a miss ends when the walk leaves the map. A hit adds the
// squaring, a square root and two more divisions, each with a setup state,
// for the hit point. The shared serial divider sets most of the cast time.
// The user must write config only while no word is in flight; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module grid_ray_wall_hit_core
  import grw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic [11:0]         in_cell_index,
  input  logic [3:0]          in_cell_value,
  input  logic [15:0]         in_origin_x,
  input  logic [15:0]         in_origin_y,
  input  logic signed [15:0]  in_dir_x,
  input  logic signed [15:0]  in_dir_y,
  // config write port
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [DIM_W-1:0]    cfg_wdata,
  // result channel
  output logic                out_valid,
  output logic                out_hit,
  output logic [1:0]          out_side,
  output logic [31:0]         out_wall_distance,
  output logic [15:0]         out_point_x,
  output logic [15:0]         out_point_y
);

  logic [DIM_W-1:0] grid_width_r;
  logic [DIM_W-1:0] grid_height_r;
  item_t            in_item;
  item_t            q_item;
  logic             q_valid;
  back_stat_t       stat;

  // config registers, both reset to a full 64x64 map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(64);
      grid_height_r <= DIM_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pack the command word
  always_comb begin
    in_item.op         = op_t'(in_operation);
    in_item.cell_index = in_cell_index;
    in_item.cell_value = in_cell_value;
    in_item.origin_x   = in_origin_x;
    in_item.origin_y   = in_origin_y;
    in_item.dir_x      = in_dir_x;
    in_item.dir_y      = in_dir_y;
  end

  grw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_item(in_item),
    .stat   (stat),
    .busy   (busy),
    .q_valid(q_valid),
    .q_item (q_item)
  );

  grw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .grid_width       (grid_width_r),
    .grid_height      (grid_height_r),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_side         (out_side),
    .out_wall_distance(out_wall_distance),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y)
  );

endmodule

[sv/grw_front.sv]
// ----------------------------------------------------------------------------
// grw_front: command intake
// Accepts words and holds them, operation included, in a two-entry
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module grw_front
  import grw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  item_t      in_item,
  input  back_stat_t stat,
  output logic       busy,
  output logic       q_valid,
  output item_t      q_item
);

  item_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               push;
  logic               pop;

  assign busy    = stat.clearing || (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign pop     = stat.pop && q_valid;
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

endmodule

[sv/grw_div.sv]
// ----------------------------------------------------------------------------
// grw_div: restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module grw_div
  import grw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] rem_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 qbit;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_NUM_W-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DIV_DEN_W'(trial - {1'b0, den_r}) : DIV_DEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], qbit};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[sv/grw_sqrt.sv]
// ----------------------------------------------------------------------------
// grw_sqrt: integer square root
// Digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module grw_sqrt
  import grw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [SQ_W-1:0]      val,
  output logic                 done,
  output logic [DIV_DEN_W-1:0] root
);

  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] res_r;
  logic [SQ_W-1:0] bit_r;
  logic [SQ_W-1:0] trial;
  logic            run_r;
  logic            done_r;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (go) begin
      v_r   <= val;
      res_r <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 1);
    end else if (run_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && bit_r[0]) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = res_r[DIV_DEN_W-1:0];

endmodule

[sv/grw_back.sv]
// ----------------------------------------------------------------------------
// grw_back: map store and ray walker
// Holds the cell map, clears it after reset, executes cell writes and
// walks rays through the grid, then works out distance and hit point.
// ----------------------------------------------------------------------------
module grw_back
  import grw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  item_t            q_item,
  input  logic [DIM_W-1:0] grid_width,
  input  logic [DIM_W-1:0] grid_height,
  output back_stat_t       stat,
  output logic             out_valid,
  output logic             out_hit,
  output logic [1:0]       out_side,
  output logic [31:0]      out_wall_distance,
  output logic [15:0]      out_point_x,
  output logic [15:0]      out_point_y
);

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_DIVX  = 16'h0004,
    S_DIVY  = 16'h0008,
    S_CRX   = 16'h0010,
    S_CRY   = 16'h0020,
    S_STEP  = 16'h0040,
    S_READ  = 16'h0080,
    S_CHECK = 16'h0100,
    S_SQX   = 16'h0200,
    S_SQY   = 16'h0400,
    S_ROOT  = 16'h0800,
    S_MULX  = 16'h1000,
    S_DIVOX = 16'h2000,
    S_MULY  = 16'h4000,
    S_DIVOY = 16'h8000
  } state_t;

  localparam int ADDR_SUM_W = ROW_W + DIM_W + 1;

  state_t state_r, state_nxt;

  logic [3:0]  map_mem [CELL_COUNT];
  logic        mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [3:0]  mem_wdata;
  logic [CELL_AW-1:0] mem_raddr;
  logic [3:0]  rd_r;
  logic [CELL_AW-1:0] clr_addr_r;

  logic [15:0] ox_r, oy_r, adx_r, ady_r, px_r;
  logic        negx_r, negy_r;
  logic [31:0] delx_r, dely_r, sx_r, sy_r, wall_r;
  logic [1:0]  side_r;
  logic signed [POS_W-1:0] mx_r, my_r;
  logic [32:0] sq_r, sq_sum;
  logic [DIV_DEN_W-1:0] len_r;

  logic [15:0] mul_a;
  logic [31:0] mul_b;
  logic [47:0] mul_p;
  logic [10:0] part_x, part_y;

  logic                 div_go_r, div_done;
  logic [DIV_NUM_W-1:0] div_num_r, div_q;
  logic [DIV_DEN_W-1:0] div_den_r;
  logic                 sqrt_go_r, sqrt_done;
  logic [SQ_W-1:0]      sqrt_in_r;
  logic [DIV_DEN_W-1:0] sqrt_root;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [ROW_W+DIM_W-1:0] row_base;
  logic [ADDR_SUM_W-1:0]  addr_sum;
  logic in_bounds;
  logic [32:0] sx_inc, sy_inc;
  logic [15:0] q_adx, q_ady;
  logic [16:0] off_sat;

  logic        out_valid_r, out_hit_r;
  logic [1:0]  out_side_r;
  logic [31:0] out_wall_r;
  logic [15:0] out_px_r, out_py_r;

  // apply one axis offset, clamped to the Q6.10 range
  function automatic logic [15:0] move_pt(logic [15:0] org, logic neg, logic [16:0] off);
    logic [17:0] s;
    logic [15:0] r;
    s = {2'b00, org} + {1'b0, off};
    if (neg) r = ({1'b0, org} >= off) ? 16'({1'b0, org} - off) : 16'd0;
    else     r = (s > 18'd65535) ? 16'hFFFF : s[15:0];
    return r;
  endfunction

  grw_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go_r),
    .num  (div_num_r),
    .den  (div_den_r),
    .done (div_done),
    .quo  (div_q)
  );

  grw_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (sqrt_go_r),
    .val  (sqrt_in_r),
    .done (sqrt_done),
    .root (sqrt_root)
  );

  // effective map size
  always_comb begin
    w_eff = ({25'd0, grid_width}  > 32'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : grid_width;
    h_eff = ({25'd0, grid_height} > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height;
    in_bounds = (mx_r >= 0) && (mx_r < $signed({{(POS_W-DIM_W){1'b0}}, w_eff})) &&
                (my_r >= 0) && (my_r < $signed({{(POS_W-DIM_W){1'b0}}, h_eff}));
    row_base  = my_r[ROW_W-1:0] * w_eff;
    addr_sum  = {1'b0, row_base} + ADDR_SUM_W'(mx_r[COL_W-1:0]);
    mem_raddr = CELL_AW'(addr_sum);
  end

  assign q_adx = q_item.dir_x[15] ? 16'(~q_item.dir_x + 16'sd1) : 16'(q_item.dir_x);
  assign q_ady = q_item.dir_y[15] ? 16'(~q_item.dir_y + 16'sd1) : 16'(q_item.dir_y);

  // shared multiplier
  assign part_x = negx_r ? {1'b0, ox_r[9:0]} : 11'd1024 - {1'b0, ox_r[9:0]};
  assign part_y = negy_r ? {1'b0, oy_r[9:0]} : 11'd1024 - {1'b0, oy_r[9:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CRX:  begin mul_a = 16'(part_x); mul_b = delx_r; end
      S_CRY:  begin mul_a = 16'(part_y); mul_b = dely_r; end
      S_SQX:  begin mul_a = adx_r; mul_b = 32'(adx_r); end
      S_SQY:  begin mul_a = ady_r; mul_b = 32'(ady_r); end
      S_MULX: begin mul_a = adx_r; mul_b = wall_r; end
      S_MULY: begin mul_a = ady_r; mul_b = wall_r; end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  assign sq_sum  = sq_r + 33'(mul_p[31:0]);
  assign sx_inc  = {1'b0, sx_r} + {1'b0, delx_r};
  assign sy_inc  = {1'b0, sy_r} + {1'b0, dely_r};
  // offset saturated to 17 bits; zero length leaves the origin
  assign off_sat = (len_r == '0) ? 17'd0 :
                   (div_q[DIV_NUM_W-1:17] != '0) ? 17'h1FFFF : div_q[16:0];

  // memory port: clear sweep, cell writes, walker reads
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = 4'd0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == S_IDLE && q_valid && q_item.op == OP_WRITE &&
                 {20'd0, q_item.cell_index} < 32'(CELL_COUNT)) begin
      mem_we    = 1'b1;
      mem_waddr = CELL_AW'(q_item.cell_index);
      mem_wdata = q_item.cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    rd_r <= map_mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == CELL_AW'(CELL_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (q_valid && q_item.op == OP_CAST) state_nxt = S_DIVX;
      S_DIVX:  if (div_done) state_nxt = S_DIVY;
      S_DIVY:  if (div_done) state_nxt = S_CRX;
      S_CRX:   state_nxt = S_CRY;
      S_CRY:   state_nxt = S_STEP;
      S_STEP:  state_nxt = S_READ;
      S_READ:  state_nxt = in_bounds ? S_CHECK : S_IDLE;
      S_CHECK: state_nxt = (rd_r != 4'd0) ? S_SQX : S_STEP;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_ROOT;
      S_ROOT:  if (sqrt_done) state_nxt = S_MULX;
      S_MULX:  state_nxt = S_DIVOX;
      S_DIVOX: if (div_done) state_nxt = S_MULY;
      S_MULY:  state_nxt = S_DIVOY;
      S_DIVOY: if (div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      div_go_r    <= 1'b0;
      sqrt_go_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_go_r    <= 1'b0;
      sqrt_go_r   <= 1'b0;
      out_valid_r <= 1'b0;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + CELL_AW'(1);
      if ((state_r == S_IDLE && q_valid && q_item.op == OP_WRITE) ||
          (state_r == S_READ && !in_bounds)) begin
        out_valid_r <= 1'b1;
      end
      if ((state_r == S_IDLE && q_valid && q_item.op == OP_CAST) ||
          (state_r == S_DIVX && div_done) || state_r == S_MULX || state_r == S_MULY) begin
        div_go_r <= 1'b1;
      end
      if (state_r == S_SQY) sqrt_go_r <= 1'b1;
      if (state_r == S_DIVOY && div_done) out_valid_r <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        out_hit_r  <= 1'b0;
        out_side_r <= 2'd0;
        out_wall_r <= '0;
        out_px_r   <= '0;
        out_py_r   <= '0;
        ox_r       <= q_item.origin_x;
        oy_r       <= q_item.origin_y;
        negx_r     <= q_item.dir_x[15];
        negy_r     <= q_item.dir_y[15];
        adx_r      <= q_adx;
        ady_r      <= q_ady;
        mx_r       <= $signed(POS_W'(q_item.origin_x[15:10]));
        my_r       <= $signed(POS_W'(q_item.origin_y[15:10]));
        div_num_r  <= ONE_Q30;
        div_den_r  <= DIV_DEN_W'(q_adx);
      end
      S_DIVX: if (div_done) begin
        delx_r    <= (adx_r == '0) ? SAT32 : div_q[31:0];
        div_num_r <= ONE_Q30;
        div_den_r <= DIV_DEN_W'(ady_r);
      end
      S_DIVY: if (div_done) dely_r <= (ady_r == '0) ? SAT32 : div_q[31:0];
      // part <= 1024, so the shifted product never passes 32 bits
      S_CRX: sx_r <= mul_p[41:10];
      S_CRY: sy_r <= mul_p[41:10];
      S_STEP: begin
        if (sx_r < sy_r) begin
          wall_r <= sx_r;
          sx_r   <= sx_inc[32] ? SAT32 : sx_inc[31:0];
          mx_r   <= negx_r ? mx_r - POS_W'(1) : mx_r + POS_W'(1);
          side_r <= 2'd1;
        end else begin
          wall_r <= sy_r;
          sy_r   <= sy_inc[32] ? SAT32 : sy_inc[31:0];
          my_r   <= negy_r ? my_r - POS_W'(1) : my_r + POS_W'(1);
          side_r <= 2'd2;
        end
      end
      S_SQX: sq_r <= 33'(mul_p[31:0]);
      S_SQY: sqrt_in_r <= {sq_sum, 16'd0};
      S_ROOT: if (sqrt_done) len_r <= sqrt_root;
      S_MULX, S_MULY: begin
        div_num_r <= {mul_p, 2'b00};
        div_den_r <= len_r;
      end
      S_DIVOX: if (div_done) px_r <= move_pt(ox_r, negx_r, off_sat);
      S_DIVOY: if (div_done) begin
        out_hit_r  <= 1'b1;
        out_side_r <= side_r;
        out_wall_r <= wall_r;
        out_px_r   <= px_r;
        out_py_r   <= move_pt(oy_r, negy_r, off_sat);
      end
      default: ;
    endcase
  end

  assign stat.clearing     = (state_r == S_CLEAR);
  assign stat.pop          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_side          = out_side_r;
  assign out_wall_distance = out_wall_r;
  assign out_point_x       = out_px_r;
  assign out_point_y       = out_py_r;

endmodule

[sv/grw_checker.sv]
// ----------------------------------------------------------------------------
// grw_checker: port-level checks
// Reset behavior and result word consistency seen on the top level ports.
// ----------------------------------------------------------------------------
module grw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_hit,
  input logic [1:0]  out_side,
  input logic [31:0] out_wall_distance,
  input logic [15:0] out_point_x,
  input logic [15:0] out_point_y
);

  // map clear starts right out of reset
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word right after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |->
      (out_side == 2'd0 && out_wall_distance == 32'd0 &&
       out_point_x == 16'd0 && out_point_y == 16'd0))
    else $error("miss word with nonzero fields");

  a_hit_side: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_side == 2'd1 || out_side == 2'd2))
    else $error("hit word without a side");

endmodule

bind grid_ray_wall_hit_core grw_checker u_grw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_hit          (out_hit),
  .out_side         (out_side),
  .out_wall_distance(out_wall_distance),
  .out_point_x      (out_point_x),
  .out_point_y      (out_point_y)
);
